// ===== rtl/core/ped_pkg.sv =====
// Shared types and constants for the protobuf event decoder.
package ped_pkg;

  localparam int unsigned VARINT_MAX_BYTES = 10;
  localparam int unsigned CFG_INDEX_W      = 4;
  localparam int unsigned CFG_DATA_W       = 16;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_TYPE         = 3'd0,
    KIND_ACTOR_START  = 3'd1,
    KIND_TARGET_START = 3'd2,
    KIND_ACTOR_BYTE   = 3'd3,
    KIND_TARGET_BYTE  = 3'd4,
    KIND_TIMESTAMP    = 3'd5,
    KIND_END          = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_TAG       = 3'd1,
    ST_ZERO_FIELD    = 3'd2,
    ST_BAD_TYPE      = 3'd3,
    ST_BAD_STRING    = 3'd4,
    ST_BAD_TIMESTAMP = 3'd5,
    ST_BAD_FIELD     = 3'd6,
    ST_MISSING       = 3'd7
  } status_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_EVENT_TYPE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STRING_LENGTH = CFG_INDEX_W'(1);

endpackage

// ===== rtl/core/ped_if.sv =====
// Channel interfaces for message bytes, decoded results and configuration writes.
interface ped_in_if import ped_pkg::*; ();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ped_out_if import ped_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [63:0] value;
  status_t     status;
  logic        last;

  modport source (output valid, output kind, output value, output status, output last,
                  input ready);
  modport sink   (input valid, input kind, input value, input status, input last,
                  output ready);
endinterface

interface ped_cfg_if import ped_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/protobuf_event_decoder.sv =====
// Streaming decoder for one fixed protobuf event message, one byte per request.
// The decoder takes one request per clock cycle while its output register can
// accept, and presents any result it causes in that register on the following
// cycle. The rate is set by that single output register: a new request is taken
// whenever the register is empty or its result is taken in the same cycle, so a
// consumer that is always ready sees a sustained rate of one byte per cycle.
// Configuration writes are taken in every cycle.
module protobuf_event_decoder import ped_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ped_in_if.sink        req,
  ped_out_if.source     rsp,
  ped_cfg_if.sink       cfg
);

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_TYPE   = 3'd1,
    PH_SLEN   = 3'd2,
    PH_SBYTES = 3'd3,
    PH_TS     = 3'd4,
    PH_SKIPV  = 3'd5,
    PH_SKIPL  = 3'd6,
    PH_SKIPB  = 3'd7
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [1:0]  cur_field, cur_field_next;
  logic [63:0] remaining, remaining_next;
  logic        type_nonzero, type_nonzero_next;
  logic        actor_nonempty, actor_nonempty_next;
  logic        target_nonempty, target_nonempty_next;
  status_t     err, err_next;

  logic [7:0]  max_event_type;
  logic [15:0] max_string_length;

  logic        out_valid;
  kind_t       out_kind;
  logic [63:0] out_value;
  status_t     out_status;
  logic        out_last;

  logic        emit;
  kind_t       emit_kind;
  logic [63:0] emit_value;
  status_t     emit_status;
  logic        emit_last;

  logic        accept;
  logic [5:0]  shamt;
  logic [63:0] varint;
  logic [3:0]  byte_count_inc;
  logic [31:0] tag_field;
  logic [2:0]  tag_wt;
  status_t     end_status;

  function automatic status_t phase_error(input phase_t ph);
    unique case (ph)
      PH_TAG:              return ST_BAD_TAG;
      PH_TYPE:             return ST_BAD_TYPE;
      PH_SLEN, PH_SBYTES:  return ST_BAD_STRING;
      PH_TS:               return ST_BAD_TIMESTAMP;
      default:             return ST_BAD_FIELD;
    endcase
  endfunction

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid  = out_valid;
  assign rsp.kind   = out_kind;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  assign shamt          = 6'(7'(byte_count) * 7'd7);
  assign varint         = acc | ({56'd0, 1'b0, req.data_byte[6:0]} << shamt);
  assign byte_count_inc = byte_count + 4'd1;
  assign tag_field      = varint[34:3];
  assign tag_wt         = varint[2:0];

  always_comb begin
    end_status = err;
    if (end_status == ST_OK && (phase != PH_TAG || byte_count != 4'd0)) begin
      end_status = phase_error(phase);
    end
    if (end_status == ST_OK && !(type_nonzero && actor_nonempty && target_nonempty)) begin
      end_status = ST_MISSING;
    end
  end

  always_comb begin
    phase_next           = phase;
    acc_next             = acc;
    byte_count_next      = byte_count;
    cur_field_next       = cur_field;
    remaining_next       = remaining;
    type_nonzero_next    = type_nonzero;
    actor_nonempty_next  = actor_nonempty;
    target_nonempty_next = target_nonempty;
    err_next             = err;
    emit                 = 1'b0;
    emit_kind            = KIND_END;
    emit_value           = 64'd0;
    emit_status          = ST_OK;
    emit_last            = 1'b0;

    if (req.op == OP_END) begin
      emit                 = 1'b1;
      emit_status          = end_status;
      emit_last            = 1'b1;
      phase_next           = PH_TAG;
      acc_next             = 64'd0;
      byte_count_next      = 4'd0;
      cur_field_next       = 2'd0;
      remaining_next       = 64'd0;
      type_nonzero_next    = 1'b0;
      actor_nonempty_next  = 1'b0;
      target_nonempty_next = 1'b0;
      err_next             = ST_OK;
    end else if (err != ST_OK) begin
      emit = 1'b0;
    end else if (phase == PH_SBYTES || phase == PH_SKIPB) begin
      remaining_next = remaining - 64'd1;
      if (phase == PH_SBYTES) begin
        emit       = 1'b1;
        emit_kind  = (cur_field == 2'd2) ? KIND_ACTOR_BYTE : KIND_TARGET_BYTE;
        emit_value = {56'd0, req.data_byte};
      end
      if (remaining == 64'd1) begin
        phase_next = PH_TAG;
      end
    end else if (req.data_byte[7]) begin
      if (32'(byte_count_inc) >= VARINT_MAX_BYTES) begin
        err_next        = phase_error(phase);
        acc_next        = 64'd0;
        byte_count_next = 4'd0;
      end else begin
        acc_next        = varint;
        byte_count_next = byte_count_inc;
      end
    end else begin
      acc_next        = 64'd0;
      byte_count_next = 4'd0;
      unique case (phase)
        PH_TAG: begin
          priority if (tag_field == 32'd0) begin
            err_next = ST_ZERO_FIELD;
          end else if (tag_field == 32'd1 && tag_wt == 3'd0) begin
            phase_next = PH_TYPE;
          end else if ((tag_field == 32'd2 || tag_field == 32'd3) && tag_wt == 3'd2) begin
            cur_field_next = tag_field[1:0];
            phase_next     = PH_SLEN;
          end else if (tag_field == 32'd4 && tag_wt == 3'd0) begin
            phase_next = PH_TS;
          end else if (tag_wt == 3'd0) begin
            phase_next = PH_SKIPV;
          end else if (tag_wt == 3'd2) begin
            phase_next = PH_SKIPL;
          end else begin
            err_next = ST_BAD_FIELD;
          end
        end
        PH_TYPE: begin
          if (varint > {56'd0, max_event_type}) begin
            err_next = ST_BAD_TYPE;
          end else begin
            type_nonzero_next = (varint != 64'd0);
            phase_next        = PH_TAG;
            emit              = 1'b1;
            emit_kind         = KIND_TYPE;
            emit_value        = varint;
          end
        end
        PH_SLEN: begin
          if (varint > {48'd0, max_string_length}) begin
            err_next = ST_BAD_STRING;
          end else begin
            if (cur_field == 2'd2) begin
              actor_nonempty_next = (varint != 64'd0);
            end else begin
              target_nonempty_next = (varint != 64'd0);
            end
            emit       = 1'b1;
            emit_kind  = (cur_field == 2'd2) ? KIND_ACTOR_START : KIND_TARGET_START;
            emit_value = varint;
            if (varint == 64'd0) begin
              phase_next = PH_TAG;
            end else begin
              remaining_next = varint;
              phase_next     = PH_SBYTES;
            end
          end
        end
        PH_TS: begin
          if (varint[63]) begin
            err_next = ST_BAD_TIMESTAMP;
          end else begin
            phase_next = PH_TAG;
            emit       = 1'b1;
            emit_kind  = KIND_TIMESTAMP;
            emit_value = varint;
          end
        end
        PH_SKIPV: begin
          phase_next = PH_TAG;
        end
        PH_SKIPL: begin
          if (varint == 64'd0) begin
            phase_next = PH_TAG;
          end else begin
            remaining_next = varint;
            phase_next     = PH_SKIPB;
          end
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      acc               <= 64'd0;
      byte_count        <= 4'd0;
      cur_field         <= 2'd0;
      remaining         <= 64'd0;
      type_nonzero      <= 1'b0;
      actor_nonempty    <= 1'b0;
      target_nonempty   <= 1'b0;
      err               <= ST_OK;
      max_event_type    <= 8'd3;
      max_string_length <= 16'd1024;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_MAX_EVENT_TYPE) begin
          max_event_type <= cfg.data[7:0];
        end else if (cfg.index == CFG_MAX_STRING_LENGTH) begin
          max_string_length <= cfg.data;
        end
      end
      if (accept) begin
        phase           <= phase_next;
        acc             <= acc_next;
        byte_count      <= byte_count_next;
        cur_field       <= cur_field_next;
        remaining       <= remaining_next;
        type_nonzero    <= type_nonzero_next;
        actor_nonempty  <= actor_nonempty_next;
        target_nonempty <= target_nonempty_next;
        err             <= err_next;
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept && emit) begin
      out_kind   <= emit_kind;
      out_value  <= emit_value;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  // A string or skipped body always has at least one byte left to consume.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SBYTES || phase == PH_SKIPB) |-> remaining != 64'd0)
    else $error("body phase with no bytes left");

  // A varint never grows beyond its maximum length.
  assert property (@(posedge clk) disable iff (rst)
    32'(byte_count) < VARINT_MAX_BYTES)
    else $error("varint byte count out of range");

  // An end-of-message request leaves the parser cleared for the next message.
  assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_END) |=> (phase == PH_TAG && err == ST_OK &&
                                      byte_count == 4'd0 && !type_nonzero))
    else $error("message state not cleared after end");

  // Only the message end result carries a status.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_OK && out_kind != KIND_END))
    else $error("status on a non-final result");

  // Once an error is latched, data bytes produce no new result.
  assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_BYTE && err != ST_OK && rsp.ready) |=> !out_valid)
    else $error("result produced after an error");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the protobuf event decoder: directed and random messages.
module testbench;
  import ped_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    status_t     status;
    logic        last;
  } dec_result_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    bit          typed;
    kind_t       kind;
    status_t     status;
    logic [63:0] value;
  } plan_row_t;

  typedef enum logic [2:0] {
    PS_TAG, PS_TYPE, PS_SLEN, PS_SBYTES, PS_TS, PS_SKIPV, PS_SKIPL, PS_SKIPB
  } parse_state_t;

  typedef enum int unsigned {
    PART_TYPE, PART_ACTOR, PART_TARGET, PART_TIME, PART_SKIP_VARINT, PART_SKIP_LEN
  } part_t;

  typedef enum int unsigned {
    BRK_TRUNCATE, BRK_WIRE_TYPE, BRK_ZERO_FIELD, BRK_OVERLONG
  } break_t;

  localparam logic [31:0] FIELD_TYPE   = 32'd1;
  localparam logic [31:0] FIELD_ACTOR  = 32'd2;
  localparam logic [31:0] FIELD_TARGET = 32'd3;
  localparam logic [31:0] FIELD_TIME   = 32'd4;
  localparam logic [2:0]  WT_VARINT    = 3'd0;
  localparam logic [2:0]  WT_LEN       = 3'd2;
  localparam int unsigned PHASE_ITEMS  = 175;

  localparam plan_row_t PLAN [24] = '{
    '{OP_END,  8'h5A, 1'b1, KIND_END,          ST_MISSING,       64'd0},
    '{OP_BYTE, 8'h08, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h03, 1'b1, KIND_TYPE,         ST_OK,            64'd3},
    '{OP_BYTE, 8'h12, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h01, 1'b1, KIND_ACTOR_START,  ST_OK,            64'd1},
    '{OP_BYTE, 8'hFF, 1'b1, KIND_ACTOR_BYTE,   ST_OK,            64'hFF},
    '{OP_BYTE, 8'h1A, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h01, 1'b1, KIND_TARGET_START, ST_OK,            64'd1},
    '{OP_BYTE, 8'h00, 1'b1, KIND_TARGET_BYTE,  ST_OK,            64'd0},
    '{OP_BYTE, 8'h2A, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h01, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'hAA, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h20, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h00, 1'b1, KIND_TIMESTAMP,    ST_OK,            64'd0},
    '{OP_END,  8'hA5, 1'b1, KIND_END,          ST_OK,            64'd0},
    '{OP_BYTE, 8'h0B, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_END,  8'h00, 1'b1, KIND_END,          ST_BAD_FIELD,     64'd0},
    '{OP_BYTE, 8'h00, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_END,  8'hFF, 1'b1, KIND_END,          ST_ZERO_FIELD,    64'd0},
    '{OP_BYTE, 8'h08, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_BYTE, 8'h04, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_END,  8'h3C, 1'b1, KIND_END,          ST_BAD_TYPE,      64'd0},
    '{OP_BYTE, 8'h88, 1'b0, KIND_TYPE,         ST_OK,            64'd0},
    '{OP_END,  8'hC3, 1'b1, KIND_END,          ST_BAD_TAG,       64'd0}
  };

  logic clk = 1'b0;
  logic rst;

  ped_in_if  req ();
  ped_out_if rsp ();
  ped_cfg_if cfg ();

  protobuf_event_decoder dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #10 clk = ~clk;

  logic [7:0]   lim_type;
  logic [15:0]  lim_len;
  parse_state_t ps;
  logic [63:0]  acc;
  int unsigned  acc_bytes;
  logic [1:0]   str_field;
  logic [63:0]  bytes_left;
  bit           type_set;
  bit           actor_set;
  bit           target_set;
  status_t      fault;

  dec_result_t  awaited[$];
  dec_result_t  oldest;
  logic [7:0]   msg[$];
  int           failures = 0;
  int unsigned  counted;
  int unsigned  snd_idle;
  int unsigned  rcv_idle;

  function automatic void clear_message();
    ps         = PS_TAG;
    acc        = '0;
    acc_bytes  = 0;
    str_field  = '0;
    bytes_left = '0;
    type_set   = 1'b0;
    actor_set  = 1'b0;
    target_set = 1'b0;
    fault      = ST_OK;
  endfunction

  function automatic status_t state_fault();
    case (ps)
      PS_TAG:            return ST_BAD_TAG;
      PS_TYPE:           return ST_BAD_TYPE;
      PS_SLEN, PS_SBYTES: return ST_BAD_STRING;
      PS_TS:             return ST_BAD_TIMESTAMP;
      default:           return ST_BAD_FIELD;
    endcase
  endfunction

  function automatic bit decode_byte(input op_t op, input logic [7:0] b,
                                     output dec_result_t res);
    logic [63:0] v;
    logic [31:0] fnum;
    logic [2:0]  wt;
    status_t     st;
    bit          has;
    res = '0;
    has = 1'b0;
    if (op == OP_END) begin
      st = fault;
      if (st == ST_OK && (ps != PS_TAG || acc_bytes != 0)) st = state_fault();
      if (st == ST_OK && !(type_set && actor_set && target_set)) st = ST_MISSING;
      res.kind = KIND_END;
      res.status = st;
      res.last = 1'b1;
      clear_message();
      return 1'b1;
    end
    if (fault != ST_OK) return 1'b0;
    if (ps == PS_SBYTES || ps == PS_SKIPB) begin
      bytes_left = bytes_left - 64'd1;
      if (ps == PS_SBYTES) begin
        res.kind = (str_field == FIELD_ACTOR[1:0]) ? KIND_ACTOR_BYTE : KIND_TARGET_BYTE;
        res.value = 64'(b);
        has = 1'b1;
      end
      if (bytes_left == 0) ps = PS_TAG;
      return has;
    end
    if (7 * acc_bytes < 64) acc = acc | (64'(b[6:0]) << (7 * acc_bytes));
    if (b[7]) begin
      acc_bytes++;
      if (acc_bytes >= VARINT_MAX_BYTES) begin
        fault = state_fault();
        acc = '0;
        acc_bytes = 0;
      end
      return 1'b0;
    end
    v = acc;
    acc = '0;
    acc_bytes = 0;
    case (ps)
      PS_TAG: begin
        fnum = v[34:3];
        wt = v[2:0];
        if (fnum == 0) begin
          fault = ST_ZERO_FIELD;
        end else if (fnum == FIELD_TYPE && wt == WT_VARINT) begin
          ps = PS_TYPE;
        end else if ((fnum == FIELD_ACTOR || fnum == FIELD_TARGET) && wt == WT_LEN) begin
          str_field = fnum[1:0];
          ps = PS_SLEN;
        end else if (fnum == FIELD_TIME && wt == WT_VARINT) begin
          ps = PS_TS;
        end else if (wt == WT_VARINT) begin
          ps = PS_SKIPV;
        end else if (wt == WT_LEN) begin
          ps = PS_SKIPL;
        end else begin
          fault = ST_BAD_FIELD;
        end
      end
      PS_TYPE: begin
        if (v > 64'(lim_type)) begin
          fault = ST_BAD_TYPE;
        end else begin
          type_set = (v != 0);
          ps = PS_TAG;
          res.kind = KIND_TYPE;
          res.value = v;
          has = 1'b1;
        end
      end
      PS_SLEN: begin
        if (v > 64'(lim_len)) begin
          fault = ST_BAD_STRING;
        end else begin
          if (str_field == FIELD_ACTOR[1:0]) actor_set = (v != 0);
          else target_set = (v != 0);
          res.kind = (str_field == FIELD_ACTOR[1:0]) ? KIND_ACTOR_START : KIND_TARGET_START;
          res.value = v;
          has = 1'b1;
          if (v == 0) begin
            ps = PS_TAG;
          end else begin
            bytes_left = v;
            ps = PS_SBYTES;
          end
        end
      end
      PS_TS: begin
        if (v[63]) begin
          fault = ST_BAD_TIMESTAMP;
        end else begin
          ps = PS_TAG;
          res.kind = KIND_TIMESTAMP;
          res.value = v;
          has = 1'b1;
        end
      end
      PS_SKIPV: ps = PS_TAG;
      default: begin
        if (v == 0) begin
          ps = PS_TAG;
        end else begin
          bytes_left = v;
          ps = PS_SKIPB;
        end
      end
    endcase
    return has;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    msg.insert(msg.size(), b);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned some_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  function automatic void put_varint(input logic [63:0] v, input int unsigned pad);
    int          n;
    int          total;
    logic [63:0] t;
    logic [6:0]  grp;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    total = (n + int'(pad) > 10) ? 10 : n + int'(pad);
    t = v;
    for (int i = 0; i < total; i++) begin
      grp = t[6:0];
      t = t >> 7;
      if (i == 9) grp[6:1] = 6'($urandom);
      add_byte({(i < total - 1), grp});
    end
  endfunction

  function automatic void put_tag(input logic [31:0] fnum, input logic [2:0] wt);
    logic [63:0] t;
    t = {29'd0, fnum, wt};
    if ($urandom_range(0, 15) == 0) t[63:35] = 29'(rand64());
    put_varint(t, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  function automatic logic [31:0] unknown_field();
    logic [31:0] f;
    case ($urandom_range(0, 3))
      0: f = $urandom;
      1: f = $urandom_range(1, 4);
      default: f = $urandom_range(5, 40);
    endcase
    return (f == 0) ? 32'd9 : f;
  endfunction

  function automatic void put_field(input part_t part);
    logic [63:0] v;
    logic [31:0] fnum;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    case (part)
      PART_TYPE: begin
        put_tag(FIELD_TYPE, WT_VARINT);
        if (sel == 0) v = 64'(lim_type) + 64'd1;
        else if (sel == 1) v = rand64() >> $urandom_range(0, 56);
        else v = 64'($urandom_range(0, lim_type));
        put_varint(v, some_pad());
      end
      PART_ACTOR, PART_TARGET: begin
        put_tag((part == PART_ACTOR) ? FIELD_ACTOR : FIELD_TARGET, WT_LEN);
        if (sel == 0) v = 64'(lim_len) + 64'd1;
        else if (sel == 1) v = rand64() | 64'h100_0000_0000;
        else if (sel == 2 && lim_len <= 16'd40) v = 64'(lim_len);
        else v = 64'($urandom_range(0, (lim_len < 16'd8) ? lim_len : 8));
        put_varint(v, some_pad());
        if (v > 64'(lim_len)) v = 64'($urandom_range(0, 2));
        repeat (int'(v)) add_byte(8'($urandom));
      end
      PART_TIME: begin
        put_tag(FIELD_TIME, WT_VARINT);
        if (sel == 0) v = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (sel == 1) v = 64'h8000_0000_0000_0000;
        else if (sel == 2) v = rand64() | 64'h8000_0000_0000_0000;
        else if (sel < 9) v = 64'($urandom_range(0, 300));
        else v = rand64() >> $urandom_range(1, 60);
        put_varint(v, some_pad());
      end
      PART_SKIP_VARINT: begin
        fnum = unknown_field();
        if (fnum == FIELD_TYPE || fnum == FIELD_TIME) fnum = fnum + 32'd4;
        put_tag(fnum, WT_VARINT);
        put_varint(rand64() >> $urandom_range(0, 63), some_pad());
      end
      default: begin
        fnum = unknown_field();
        if (fnum == FIELD_ACTOR || fnum == FIELD_TARGET) fnum = fnum + 32'd4;
        put_tag(fnum, WT_LEN);
        v = 64'($urandom_range(0, 5));
        put_varint(v, some_pad());
        repeat (int'(v)) add_byte(8'($urandom));
      end
    endcase
  endfunction

  function automatic void build_message();
    part_t       order[$];
    part_t       tmp;
    int unsigned mode;
    int unsigned j;
    int unsigned w;
    mode = $urandom_range(0, 99);
    msg.delete();
    if (mode < 3) return;
    if (mode < 10) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      return;
    end
    order = '{PART_TYPE, PART_ACTOR, PART_TARGET, PART_TIME};
    repeat ($urandom_range(0, 3)) order.insert(order.size(), part_t'($urandom_range(0, 5)));
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if ($urandom_range(0, 9) == 0) order.delete($urandom_range(0, order.size() - 1));
    foreach (order[k]) put_field(order[k]);
    if (mode < 75) return;
    case (break_t'($urandom_range(0, 3)))
      BRK_TRUNCATE: begin
        repeat ($urandom_range(1, 4)) if (msg.size() != 0) void'(msg.pop_back());
      end
      BRK_WIRE_TYPE: begin
        w = $urandom_range(3, 8);
        put_tag($urandom_range(1, 40), (w == 8) ? 3'd1 : 3'(w));
      end
      BRK_ZERO_FIELD: put_tag(32'd0, 3'($urandom));
      default: begin
        case ($urandom_range(0, 5))
          1: put_tag(FIELD_TYPE, WT_VARINT);
          2: put_tag(FIELD_TIME, WT_VARINT);
          3: put_tag(FIELD_ACTOR, WT_LEN);
          4: put_tag(32'd9, WT_VARINT);
          5: put_tag(32'd9, WT_LEN);
          default: ;
        endcase
        repeat (10) add_byte({1'b1, 7'($urandom)});
      end
    endcase
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      failures++;
    end
  endfunction

  task automatic send_item(input op_t op, input logic [7:0] b, input bit typed,
                           input dec_result_t typed_res);
    dec_result_t res;
    bit          has;
    while ($urandom_range(0, 99) < snd_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.data_byte <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    counted++;
    has = decode_byte(op, b, res);
    if (typed) awaited.insert(awaited.size(), typed_res);
    else if (has) awaited.insert(awaited.size(), res);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_MAX_EVENT_TYPE:    lim_type = d[7:0];
      CFG_MAX_STRING_LENGTH: lim_len = d;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] mt, input logic [15:0] ml);
    cfg_put(CFG_MAX_EVENT_TYPE, {8'($urandom), mt});
    cfg_put(CFG_MAX_STRING_LENGTH, ml);
    cfg_put(CFG_INDEX_W'($urandom_range(2, 15)), 16'($urandom));
    cfg.valid <= 1'b0;
  endtask

  task automatic run_messages(input int unsigned quota);
    counted = 0;
    while (counted < quota) begin
      build_message();
      foreach (msg[k]) send_item(OP_BYTE, msg[k], 1'b0, '0);
      send_item(OP_END, 8'($urandom), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d value %h status %0d last %0b",
                 $time, rsp.kind, rsp.value, rsp.status, rsp.last);
        failures++;
      end else begin
        oldest = awaited.pop_front();
        check_field("kind", 64'(oldest.kind), 64'(rsp.kind));
        check_field("value", oldest.value, rsp.value);
        check_field("status", 64'(oldest.status), 64'(rsp.status));
        check_field("last", 64'(oldest.last), 64'(rsp.last));
      end
    end
    rsp.ready <= !rst && ($urandom_range(0, 99) >= rcv_idle);
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    dec_result_t typed_res;
    logic [7:0]  mt;
    logic [15:0] ml;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.op        = OP_BYTE;
    req.data_byte = 8'h00;
    rsp.ready     = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = '0;
    cfg.data      = '0;
    lim_type      = 8'd3;
    lim_len       = 16'd1024;
    clear_message();
    snd_idle      = 28;
    rcv_idle      = 45;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      typed_res.kind   = PLAN[i].kind;
      typed_res.value  = PLAN[i].value;
      typed_res.status = PLAN[i].status;
      typed_res.last   = (PLAN[i].kind == KIND_END);
      send_item(PLAN[i].op, PLAN[i].data, PLAN[i].typed, typed_res);
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin mt = 8'd255; ml = 16'd65535; end
        1: begin mt = 8'd0; ml = 16'd1; end
        2: begin mt = 8'd1; ml = 16'd40; end
        3: begin mt = 8'($urandom); ml = 16'($urandom_range(1, 20)); end
        4: begin mt = 8'($urandom); ml = 16'd1024; end
        default: begin mt = 8'($urandom); ml = 16'($urandom_range(1, 65535)); end
      endcase
      if (p == 2) begin
        snd_idle = 45;
        rcv_idle = 28;
      end else if (p == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      configure(mt, ml);
      run_messages(PHASE_ITEMS);
      drain();
    end

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ped_pkg.sv
rtl/core/ped_if.sv
rtl/core/protobuf_event_decoder.sv
tb/testbench.sv
